// File: rtl/fahc_pkg.sv
package fahc_pkg;

  localparam int unsigned MV_FULL  = 3300;
  localparam int unsigned RAW_FULL = 4095;

  typedef enum logic [1:0] {
    SMOKE_NORMAL = 2'd0,
    SMOKE_WARN   = 2'd1,
    SMOKE_DANGER = 2'd2
  } smoke_class_t;

  typedef enum logic [1:0] {
    ALARM_OFF    = 2'd0,
    ALARM_BEEP   = 2'd1,
    ALARM_DANGER = 2'd2
  } alarm_t;

  typedef enum logic {
    ITEM_SAMPLE = 1'b0,
    ITEM_TICK   = 1'b1
  } item_kind_t;

  // register index, taken from paddr[4:2]
  localparam logic [2:0] REG_SMOKE_WARN   = 3'd0;
  localparam logic [2:0] REG_SMOKE_DANGER = 3'd1;
  localparam logic [2:0] REG_SMOKE_HYST   = 3'd2;
  localparam logic [2:0] REG_TEMP_WARN    = 3'd3;
  localparam logic [2:0] REG_TEMP_DANGER  = 3'd4;
  localparam logic [2:0] REG_HUM_WARN     = 3'd5;
  localparam logic [2:0] REG_PUMP_ON      = 3'd6;
  localparam logic [2:0] REG_FAN_ON       = 3'd7;

  typedef struct packed {
    logic [11:0] warn_level;
    logic [11:0] danger_level;
    logic [9:0]  smoke_margin;
    logic [7:0]  temp_warn_c;
    logic [7:0]  heat_limit;
    logic [7:0]  hum_warn_pct;
    logic [7:0]  pump_on_c;
    logic [7:0]  fan_on_c;
  } fahc_cfg_t;

  // request as held in the input register, smoke already in millivolts
  typedef struct packed {
    item_kind_t  kind;
    logic [11:0] smoke_milli;
    logic        flame;
    logic        dht_ok;
    logic [7:0]  temp_c;
    logic [7:0]  hum_pct;
  } fahc_item_t;

  typedef struct packed {
    smoke_class_t smoke_class;
    logic         pump_drive;
    logic         fan_drive;
    logic         buzzer_drive;
    alarm_t       alarm_level;
    logic [7:0]   humidity_shown;
    logic [7:0]   temperature_shown;
    logic         temp_warning;
    logic         humidity_warning;
    logic         reading_valid;
  } fahc_result_t;

  // raw*3300/4095: divide by 4096 first, the remainder then stays below 2*4095
  function automatic logic [11:0] mv_scale(input logic [11:0] raw);
    logic [23:0] prod;
    logic [11:0] q0;
    logic [12:0] r0;
    prod = 24'(raw) * 24'(MV_FULL);
    q0   = prod[23:12];
    r0   = 13'(prod[11:0]) + 13'(q0);
    return (r0 >= 13'(RAW_FULL)) ? q0 + 12'd1 : q0;
  endfunction

endpackage

// File: rtl/fahc_if.sv
interface fahc_item_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic [11:0] smoke_raw;
  logic        flame;
  logic        dht_ok;
  logic [7:0]  temp_c;
  logic [7:0]  hum_pct;

  modport source (
    output valid, mode, smoke_raw, flame, dht_ok, temp_c, hum_pct,
    input  ready
  );
  modport sink (
    input  valid, mode, smoke_raw, flame, dht_ok, temp_c, hum_pct,
    output ready
  );
endinterface

interface fahc_result_if;
  logic       valid;
  logic       ready;
  logic [1:0] smoke_class;
  logic       pump_drive;
  logic       fan_drive;
  logic       buzzer_drive;
  logic [1:0] alarm_level;
  logic [7:0] humidity_shown;
  logic [7:0] temperature_shown;
  logic       temp_warning;
  logic       humidity_warning;
  logic       reading_valid;

  modport source (
    output valid, smoke_class, pump_drive, fan_drive, buzzer_drive, alarm_level,
           humidity_shown, temperature_shown, temp_warning, humidity_warning,
           reading_valid,
    input  ready
  );
  modport sink (
    input  valid, smoke_class, pump_drive, fan_drive, buzzer_drive, alarm_level,
           humidity_shown, temperature_shown, temp_warning, humidity_warning,
           reading_valid,
    output ready
  );
endinterface

// File: rtl/fire_alarm_hysteresis_controller.sv
// Flow: an accepted request is held in the input register and moves into the state registers
// once the result slot is free; the result is then valid from the state registers.
// Throughput: one request per cycle while results are taken; the state registers double as the result register,
// and one further request can wait in the input register while a result is held.
// Reset (rst, synchronous): state, flags, buzzer pattern and pipeline valids clear;
// configuration registers return to their documented defaults.
module fire_alarm_hysteresis_controller
  import fahc_pkg::*;
#(
  parameter int unsigned BEEP_ON_TICKS  = 80,
  parameter int unsigned BEEP_OFF_TICKS = 420
) (
  input  logic          clk,
  input  logic          rst,
  fahc_item_if.sink     item_in,
  fahc_result_if.source result,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [4:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready
);

  fahc_cfg_t    cfg;
  fahc_item_t   s1_item;
  fahc_result_t res;
  logic         s1_valid;
  logic         out_valid;
  logic         fire;
  logic         accept;

  fahc_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // state update happens only when the result slot is free
  assign fire          = s1_valid && (!out_valid || result.ready);
  assign item_in.ready = !s1_valid || fire;
  assign accept        = item_in.valid && item_in.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (accept)    s1_valid <= 1'b1;
      else if (fire) s1_valid <= 1'b0;
      if (fire)              out_valid <= 1'b1;
      else if (result.ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item.kind        <= item_kind_t'(item_in.mode);
      s1_item.smoke_milli <= mv_scale(item_in.smoke_raw);
      s1_item.flame       <= item_in.flame;
      s1_item.dht_ok      <= item_in.dht_ok;
      s1_item.temp_c      <= item_in.temp_c;
      s1_item.hum_pct     <= item_in.hum_pct;
    end
  end

  fahc_core #(
    .BEEP_ON_TICKS  (BEEP_ON_TICKS),
    .BEEP_OFF_TICKS (BEEP_OFF_TICKS)
  ) u_core (
    .clk  (clk),
    .rst  (rst),
    .fire (fire),
    .item (s1_item),
    .cfg  (cfg),
    .res  (res)
  );

  assign result.valid             = out_valid;
  assign result.smoke_class       = res.smoke_class;
  assign result.pump_drive        = res.pump_drive;
  assign result.fan_drive         = res.fan_drive;
  assign result.buzzer_drive      = res.buzzer_drive;
  assign result.alarm_level       = res.alarm_level;
  assign result.humidity_shown    = res.humidity_shown;
  assign result.temperature_shown = res.temperature_shown;
  assign result.temp_warning      = res.temp_warning;
  assign result.humidity_warning  = res.humidity_warning;
  assign result.reading_valid     = res.reading_valid;

endmodule

// File: rtl/fahc_cfg.sv
module fahc_cfg
  import fahc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output fahc_cfg_t   cfg
);

  logic       wr_en;
  logic [2:0] idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.warn_level   <= 12'd1600;
      cfg.danger_level <= 12'd2000;
      cfg.smoke_margin <= 10'd50;
      cfg.temp_warn_c  <= 8'd40;
      cfg.heat_limit   <= 8'd60;
      cfg.hum_warn_pct <= 8'd80;
      cfg.pump_on_c    <= 8'd26;
      cfg.fan_on_c     <= 8'd27;
    end else if (wr_en) begin
      case (idx)
        REG_SMOKE_WARN:   cfg.warn_level   <= pwdata[11:0];
        REG_SMOKE_DANGER: cfg.danger_level <= pwdata[11:0];
        REG_SMOKE_HYST:   cfg.smoke_margin <= pwdata[9:0];
        REG_TEMP_WARN:    cfg.temp_warn_c  <= pwdata[7:0];
        REG_TEMP_DANGER:  cfg.heat_limit   <= pwdata[7:0];
        REG_HUM_WARN:     cfg.hum_warn_pct <= pwdata[7:0];
        REG_PUMP_ON:      cfg.pump_on_c    <= pwdata[7:0];
        REG_FAN_ON:       cfg.fan_on_c     <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_SMOKE_WARN:   prdata = 32'(cfg.warn_level);
      REG_SMOKE_DANGER: prdata = 32'(cfg.danger_level);
      REG_SMOKE_HYST:   prdata = 32'(cfg.smoke_margin);
      REG_TEMP_WARN:    prdata = 32'(cfg.temp_warn_c);
      REG_TEMP_DANGER:  prdata = 32'(cfg.heat_limit);
      REG_HUM_WARN:     prdata = 32'(cfg.hum_warn_pct);
      REG_PUMP_ON:      prdata = 32'(cfg.pump_on_c);
      REG_FAN_ON:       prdata = 32'(cfg.fan_on_c);
      default:          prdata = 32'd0;
    endcase
  end

endmodule

// File: rtl/fahc_core.sv
module fahc_core
  import fahc_pkg::*;
#(
  parameter int unsigned BEEP_ON_TICKS  = 80,
  parameter int unsigned BEEP_OFF_TICKS = 420
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         fire,
  input  fahc_item_t   item,
  input  fahc_cfg_t    cfg,
  output fahc_result_t res
);

  localparam logic [8:0] ON_LOAD  = 9'(BEEP_ON_TICKS - 1);
  localparam logic [8:0] OFF_LOAD = 9'(BEEP_OFF_TICKS - 1);

  smoke_class_t smoke_q, smoke_next;
  alarm_t       alarm_q, alarm_next, alarm_sel;
  logic         temp_warn, temp_warn_next;
  logic         hum_warn, hum_warn_next;
  logic         pump, pump_next;
  logic         fan, fan_next;
  logic [9:0]   filt, filt_next;
  logic         filt_init, filt_init_next;
  logic [7:0]   held_temp, held_temp_next;
  logic [7:0]   held_hum, held_hum_next;
  logic         held_valid, held_valid_next;
  logic         buzz, buzz_next;
  logic [8:0]   cnt, cnt_next;

  logic [12:0]  mv_hy;
  logic         ge_dng, ge_warn, below_warn_h, below_dng_h;
  logic [11:0]  filt_sum;
  logic [7:0]   h;
  logic         ok;
  logic         dng_cond, warn_cond;

  // smoke level; compares are fixed whatever the relation of the thresholds
  always_comb begin
    mv_hy        = 13'(item.smoke_milli) + 13'(cfg.smoke_margin);
    ge_dng       = item.smoke_milli >= cfg.danger_level;
    ge_warn      = item.smoke_milli >= cfg.warn_level;
    below_warn_h = mv_hy < 13'(cfg.warn_level);
    below_dng_h  = mv_hy < 13'(cfg.danger_level);
    case (smoke_q)
      SMOKE_WARN:
        smoke_next = ge_dng ? SMOKE_DANGER : (below_warn_h ? SMOKE_NORMAL : SMOKE_WARN);
      SMOKE_DANGER:
        smoke_next = !below_dng_h ? SMOKE_DANGER : (ge_warn ? SMOKE_WARN : SMOKE_NORMAL);
      default:
        smoke_next = ge_dng ? SMOKE_DANGER : (ge_warn ? SMOKE_WARN : SMOKE_NORMAL);
    endcase
  end

  always_comb begin
    ok              = item.dht_ok;
    filt_sum        = 12'(filt) * 12'd3 + 12'({item.hum_pct, 2'b00});
    filt_next       = filt;
    filt_init_next  = filt_init;
    held_temp_next  = held_temp;
    held_hum_next   = held_hum;
    held_valid_next = ok;
    temp_warn_next  = 1'b0;
    hum_warn_next   = 1'b0;
    pump_next       = 1'b0;
    fan_next        = 1'b0;
    if (ok) begin
      held_temp_next = item.temp_c;
      held_hum_next  = item.hum_pct;
      filt_next      = filt_init ? filt_sum[11:2] : {item.hum_pct, 2'b00};
      filt_init_next = 1'b1;
    end
    h = filt_next[9:2];
    if (ok) begin
      temp_warn_next = !temp_warn ? (item.temp_c >= cfg.temp_warn_c)
                                  : !(item.temp_c < cfg.temp_warn_c);
      hum_warn_next  = !hum_warn ? (h >= cfg.hum_warn_pct)
                                 : !(9'(h) + 9'd2 <= 9'(cfg.hum_warn_pct));
      pump_next      = !pump ? (item.temp_c >= cfg.pump_on_c || item.flame)
                             : !(item.temp_c < cfg.pump_on_c && !item.flame);
      fan_next       = !fan ? (item.temp_c >= cfg.fan_on_c)
                            : !(item.temp_c < cfg.fan_on_c);
    end
    dng_cond  = item.flame || smoke_next == SMOKE_DANGER ||
                (ok && item.temp_c >= cfg.heat_limit);
    warn_cond = smoke_next == SMOKE_WARN || temp_warn_next || hum_warn_next;
    if (dng_cond)       alarm_sel = ALARM_DANGER;
    else if (warn_cond) alarm_sel = ALARM_BEEP;
    else                alarm_sel = ALARM_OFF;
  end

  // alarm mode and buzzer pattern
  always_comb begin
    alarm_next = alarm_q;
    buzz_next  = buzz;
    cnt_next   = cnt;
    if (item.kind == ITEM_SAMPLE) begin
      if (alarm_sel != alarm_q) begin
        alarm_next = alarm_sel;
        buzz_next  = 1'b0;
        cnt_next   = 9'd0;
      end
    end else begin
      case (alarm_q)
        ALARM_DANGER: buzz_next = 1'b1;
        ALARM_BEEP: begin
          if (cnt == 9'd0) begin
            buzz_next = !buzz;
            cnt_next  = buzz ? OFF_LOAD : ON_LOAD;
          end else begin
            cnt_next = cnt - 9'd1;
          end
        end
        default: buzz_next = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      smoke_q    <= SMOKE_NORMAL;
      temp_warn  <= 1'b0;
      hum_warn   <= 1'b0;
      pump       <= 1'b0;
      fan        <= 1'b0;
      filt       <= 10'd0;
      filt_init  <= 1'b0;
      held_temp  <= 8'd0;
      held_hum   <= 8'd0;
      held_valid <= 1'b0;
      alarm_q    <= ALARM_OFF;
      buzz       <= 1'b0;
      cnt        <= 9'd0;
    end else if (fire) begin
      alarm_q <= alarm_next;
      buzz    <= buzz_next;
      cnt     <= cnt_next;
      if (item.kind == ITEM_SAMPLE) begin
        smoke_q    <= smoke_next;
        temp_warn  <= temp_warn_next;
        hum_warn   <= hum_warn_next;
        pump       <= pump_next;
        fan        <= fan_next;
        filt       <= filt_next;
        filt_init  <= filt_init_next;
        held_temp  <= held_temp_next;
        held_hum   <= held_hum_next;
        held_valid <= held_valid_next;
      end
    end
  end

  assign res.smoke_class       = smoke_q;
  assign res.pump_drive        = pump;
  assign res.fan_drive         = fan;
  assign res.buzzer_drive      = buzz;
  assign res.alarm_level       = alarm_q;
  assign res.humidity_shown    = held_valid ? filt[9:2] : held_hum;
  assign res.temperature_shown = held_temp;
  assign res.temp_warning      = temp_warn;
  assign res.humidity_warning  = hum_warn;
  assign res.reading_valid     = held_valid;

`ifndef SYNTHESIS
  a_danger_tick: assert property (@(posedge clk) disable iff (rst)
    fire && item.kind == ITEM_TICK && alarm_q == ALARM_DANGER |=> buzz)
    else $error("danger tick did not drive buzzer");

  a_invalid_clears: assert property (@(posedge clk) disable iff (rst)
    fire && item.kind == ITEM_SAMPLE && !item.dht_ok
      |=> !pump && !fan && !temp_warn && !hum_warn)
    else $error("invalid reading left a drive or flag set");

  a_mode_change: assert property (@(posedge clk) disable iff (rst)
    fire && item.kind == ITEM_SAMPLE && alarm_sel != alarm_q
      |=> cnt == 9'd0 && !buzz)
    else $error("alarm mode change did not restart pattern");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    !fire |=> $stable(smoke_q) && $stable(alarm_q) && $stable(cnt) && $stable(filt))
    else $error("state moved without a request");
`endif

endmodule

// File: verif/testbench.sv
`timescale 1ns / 1ps

module testbench
  import fahc_pkg::*;
();

  localparam int BEEP_ON  = 80;
  localparam int BEEP_OFF = 420;
  localparam int STALL_LIMIT = 5000;

  typedef struct packed {
    item_kind_t  mode;
    logic [11:0] smoke_raw;
    logic        flame;
    logic        dht_ok;
    logic [7:0]  temp_c;
    logic [7:0]  hum_pct;
  } sensor_req_t;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  fahc_item_if   sensor_ch();
  fahc_result_if status_ch();

  fire_alarm_hysteresis_controller #(
    .BEEP_ON_TICKS (BEEP_ON),
    .BEEP_OFF_TICKS(BEEP_OFF)
  ) DUT (
    .clk    (clk),
    .rst    (rst),
    .item_in(sensor_ch),
    .result (status_ch),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  // controller shadow state
  fahc_cfg_t    thresholds;
  smoke_class_t smoke_lvl;
  alarm_t       alarm_mode;
  logic         t_warn, h_warn, pump_on, fan_on;
  logic [9:0]   hum_avg;
  logic         hum_seeded;
  logic [7:0]   temp_hold, hum_hold;
  logic         valid_hold;
  logic         buzz;
  logic [8:0]   beep_left;

  fahc_result_t pending_outputs[$];
  int mismatches;
  int send_idle_pct;
  int recv_idle_pct;
  int stall_cycles;

  always #1 clk = ~clk;

  function automatic int clip(int v, int hi);
    return (v < 0) ? 0 : ((v > hi) ? hi : v);
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("ERROR at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    mismatches++;
  endtask

  task automatic check_field(string what, int got, int want);
    if (got != want) report_mismatch(what, got, want);
  endtask

  function automatic void update_alarm(alarm_t m);
    if (alarm_mode != m) begin
      alarm_mode = m;
      buzz = 1'b0;
      beep_left = '0;
    end
  endfunction

  function automatic void predict_outputs(sensor_req_t r);
    int mv, warn, dng, hy, t, h;
    fahc_result_t o;
    if (r.mode == ITEM_TICK) begin
      case (alarm_mode)
        ALARM_DANGER: buzz = 1'b1;
        ALARM_BEEP: begin
          if (beep_left == 0) begin
            buzz = ~buzz;
            beep_left = buzz ? 9'(BEEP_ON - 1) : 9'(BEEP_OFF - 1);
          end else begin
            beep_left = beep_left - 9'd1;
          end
        end
        default: buzz = 1'b0;
      endcase
    end else begin
      mv   = (int'(r.smoke_raw) * 3300) / 4095;
      warn = int'(thresholds.warn_level);
      dng  = int'(thresholds.danger_level);
      hy   = int'(thresholds.smoke_margin);
      case (smoke_lvl)
        SMOKE_WARN: begin
          if (mv >= dng) smoke_lvl = SMOKE_DANGER;
          else if (mv < warn - hy) smoke_lvl = SMOKE_NORMAL;
        end
        SMOKE_DANGER: begin
          if (mv < dng - hy) begin
            if (mv >= warn) smoke_lvl = SMOKE_WARN;
            else smoke_lvl = SMOKE_NORMAL;
          end
        end
        default: begin
          if (mv >= dng) smoke_lvl = SMOKE_DANGER;
          else if (mv >= warn) smoke_lvl = SMOKE_WARN;
          else smoke_lvl = SMOKE_NORMAL;
        end
      endcase

      valid_hold = r.dht_ok;
      if (r.dht_ok) begin
        temp_hold = r.temp_c;
        hum_hold  = r.hum_pct;
        if (!hum_seeded) begin
          hum_avg = {r.hum_pct, 2'b00};
          hum_seeded = 1'b1;
        end else begin
          hum_avg = 10'((3 * int'(hum_avg) + 4 * int'(r.hum_pct)) / 4);
        end
        t = int'(temp_hold);
        h = int'(hum_avg[9:2]);

        if (!t_warn) begin
          if (t >= int'(thresholds.temp_warn_c)) t_warn = 1'b1;
        end else if (t <= int'(thresholds.temp_warn_c) - 1) t_warn = 1'b0;

        if (!h_warn) begin
          if (h >= int'(thresholds.hum_warn_pct)) h_warn = 1'b1;
        end else if (h <= int'(thresholds.hum_warn_pct) - 2) h_warn = 1'b0;

        if (!pump_on) begin
          if (t >= int'(thresholds.pump_on_c) || r.flame) pump_on = 1'b1;
        end else if (t <= int'(thresholds.pump_on_c) - 1 && !r.flame) pump_on = 1'b0;

        if (!fan_on) begin
          if (t >= int'(thresholds.fan_on_c)) fan_on = 1'b1;
        end else if (t <= int'(thresholds.fan_on_c) - 1) fan_on = 1'b0;
      end else begin
        // bad reading drops every flag, flame included
        t_warn  = 1'b0;
        h_warn  = 1'b0;
        pump_on = 1'b0;
        fan_on  = 1'b0;
      end

      if (r.flame || smoke_lvl == SMOKE_DANGER ||
          (r.dht_ok && temp_hold >= thresholds.heat_limit))
        update_alarm(ALARM_DANGER);
      else if (smoke_lvl == SMOKE_WARN || (r.dht_ok && (t_warn || h_warn)))
        update_alarm(ALARM_BEEP);
      else
        update_alarm(ALARM_OFF);
    end

    o.smoke_class       = smoke_lvl;
    o.pump_drive        = pump_on;
    o.fan_drive         = fan_on;
    o.buzzer_drive      = buzz;
    o.alarm_level       = alarm_mode;
    o.humidity_shown    = valid_hold ? hum_avg[9:2] : hum_hold;
    o.temperature_shown = temp_hold;
    o.temp_warning      = t_warn;
    o.humidity_warning  = h_warn;
    o.reading_valid     = valid_hold;
    pending_outputs.push_back(o);
  endfunction

  // entered and left at a falling edge
  task automatic send_request(sensor_req_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      sensor_ch.valid <= 1'b0;
      @(negedge clk);
    end
    sensor_ch.valid     <= 1'b1;
    sensor_ch.mode      <= r.mode;
    sensor_ch.smoke_raw <= r.smoke_raw;
    sensor_ch.flame     <= r.flame;
    sensor_ch.dht_ok    <= r.dht_ok;
    sensor_ch.temp_c    <= r.temp_c;
    sensor_ch.hum_pct   <= r.hum_pct;
    do @(posedge clk); while (!sensor_ch.ready);
    predict_outputs(r);
    @(negedge clk);
  endtask

  task automatic drain();
    sensor_ch.valid <= 1'b0;
    while (pending_outputs.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // the bus is left idle after the access so back-to-back writes stay apart
  task automatic write_register(logic [2:0] idx, int unsigned val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_SMOKE_WARN:   thresholds.warn_level   = 12'(val);
      REG_SMOKE_DANGER: thresholds.danger_level = 12'(val);
      REG_SMOKE_HYST:   thresholds.smoke_margin = 10'(val);
      REG_TEMP_WARN:    thresholds.temp_warn_c  = 8'(val);
      REG_TEMP_DANGER:  thresholds.heat_limit   = 8'(val);
      REG_HUM_WARN:     thresholds.hum_warn_pct = 8'(val);
      REG_PUMP_ON:      thresholds.pump_on_c    = 8'(val);
      default:          thresholds.fan_on_c     = 8'(val);
    endcase
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  task automatic apply_profile(int p);
    int unsigned v[8];
    case (p)
      0: v = '{1600, 2000, 50, 40, 60, 80, 26, 27};
      1: v = '{0, 0, 1000, 1, 0, 2, 1, 1};            // leave levels below zero
      2: v = '{3300, 3300, 0, 255, 255, 255, 255, 255};
      3: v = '{2500, 1200, 300, 30, 45, 50, 20, 35};  // warn above danger
      default: begin
        v[0] = $urandom_range(3300);
        v[1] = $urandom_range(3300);
        v[2] = $urandom_range(1000);
        v[3] = $urandom_range(255, 1);
        v[4] = $urandom_range(255);
        v[5] = $urandom_range(255, 2);
        v[6] = $urandom_range(255, 1);
        v[7] = $urandom_range(255, 1);
      end
    endcase
    write_register(REG_SMOKE_WARN,   v[0]);
    write_register(REG_SMOKE_DANGER, v[1]);
    write_register(REG_SMOKE_HYST,   v[2]);
    write_register(REG_TEMP_WARN,    v[3]);
    write_register(REG_TEMP_DANGER,  v[4]);
    write_register(REG_HUM_WARN,     v[5]);
    write_register(REG_PUMP_ON,      v[6]);
    write_register(REG_FAN_ON,       v[7]);
  endtask

  function automatic sensor_req_t sample_req(logic [11:0] raw, logic fl, logic ok,
                                             logic [7:0] t, logic [7:0] h);
    sensor_req_t r;
    r.mode = ITEM_SAMPLE;
    r.smoke_raw = raw;
    r.flame = fl;
    r.dht_ok = ok;
    r.temp_c = t;
    r.hum_pct = h;
    return r;
  endfunction

  // ticks carry random junk in the unused fields
  function automatic sensor_req_t tick_req();
    sensor_req_t r;
    r = sample_req(12'($urandom), 1'($urandom), 1'($urandom), 8'($urandom), 8'($urandom));
    r.mode = ITEM_TICK;
    return r;
  endfunction

  // samples clustered around the current thresholds, with some full-range noise
  function automatic sensor_req_t random_sample(sensor_req_t prev);
    sensor_req_t r;
    int thr;
    r.mode = ITEM_SAMPLE;
    case ($urandom_range(2))
      0: r.smoke_raw = 12'($urandom_range(4095));
      1: begin
        case ($urandom_range(3))
          0: thr = int'(thresholds.warn_level);
          1: thr = int'(thresholds.danger_level);
          2: thr = int'(thresholds.warn_level) - int'(thresholds.smoke_margin);
          default: thr = int'(thresholds.danger_level) - int'(thresholds.smoke_margin);
        endcase
        r.smoke_raw = 12'(clip(thr * 4095 / 3300 + int'($urandom_range(8)) - 4, 4095));
      end
      default: r.smoke_raw = 12'(clip(int'(prev.smoke_raw) + int'($urandom_range(60)) - 30,
                                      4095));
    endcase
    case ($urandom_range(4))
      0: thr = int'(thresholds.temp_warn_c);
      1: thr = int'(thresholds.heat_limit);
      2: thr = int'(thresholds.pump_on_c);
      3: thr = int'(thresholds.fan_on_c);
      default: thr = -1;
    endcase
    if (thr < 0) r.temp_c = 8'($urandom_range(255));
    else r.temp_c = 8'(clip(thr + int'($urandom_range(4)) - 2, 255));
    if ($urandom_range(99) < 60)
      r.hum_pct = 8'(clip(int'(thresholds.hum_warn_pct) + int'($urandom_range(8)) - 4, 255));
    else
      r.hum_pct = 8'($urandom_range(255));
    r.flame  = ($urandom_range(99) < 8);
    r.dht_ok = ($urandom_range(99) < 88);
    return r;
  endfunction

  task automatic test_directed_extremes();
    send_request(tick_req());
    send_request(sample_req(12'd0, 1'b0, 1'b0, 8'd255, 8'd255));   // invalid, nothing held yet
    send_request(sample_req(12'd4095, 1'b0, 1'b1, 8'd0, 8'd0));    // seeds the filter
    send_request(tick_req());
    send_request(sample_req(12'd2482, 1'b0, 1'b1, 8'd25, 8'd255)); // on the danger level
    send_request(sample_req(12'd2400, 1'b0, 1'b1, 8'd26, 8'd255));
    send_request(tick_req());
    send_request(tick_req());
    send_request(sample_req(12'd1900, 1'b0, 1'b1, 8'd27, 8'd255));
    send_request(sample_req(12'd1985, 1'b0, 1'b1, 8'd39, 8'd0));
    send_request(sample_req(12'd1986, 1'b0, 1'b1, 8'd40, 8'd0));
    send_request(sample_req(12'd1986, 1'b0, 1'b1, 8'd39, 8'd0));
    send_request(sample_req(12'd0, 1'b0, 1'b1, 8'd25, 8'd0));
    send_request(sample_req(12'd0, 1'b1, 1'b0, 8'd0, 8'd0));       // flame, bad reading
    send_request(tick_req());
    send_request(sample_req(12'd0, 1'b1, 1'b1, 8'd0, 8'd0));       // flame forces the pump
    send_request(sample_req(12'd0, 1'b0, 1'b1, 8'd0, 8'd0));
    send_request(sample_req(12'd0, 1'b0, 1'b1, 8'd60, 8'd100));
    send_request(sample_req(12'd0, 1'b0, 1'b1, 8'd255, 8'd100));
    send_request(sample_req(12'd4095, 1'b1, 1'b0, 8'd255, 8'd255));
    send_request(tick_req());
    send_request(sample_req(12'd0, 1'b0, 1'b1, 8'd0, 8'd255));
    send_request(sample_req(12'd0, 1'b0, 1'b1, 8'd0, 8'd0));
    send_request(tick_req());
  endtask

  task automatic test_beep_pattern();
    send_request(sample_req(12'd2234, 1'b0, 1'b1, 8'd20, 8'd20));  // smoke warning
    repeat (BEEP_ON + BEEP_OFF + 10) send_request(tick_req());
    send_request(sample_req(12'd4095, 1'b0, 1'b1, 8'd20, 8'd20));
    repeat (3) send_request(tick_req());
    send_request(sample_req(12'd2234, 1'b0, 1'b1, 8'd20, 8'd20));
    repeat (100) send_request(tick_req());
    send_request(sample_req(12'd0, 1'b0, 1'b0, 8'd20, 8'd20));
    repeat (3) send_request(tick_req());
  endtask

  task automatic test_random_traffic(int n);
    sensor_req_t r;
    int sent, burst;
    sent = 0;
    r = sample_req(12'd0, 1'b0, 1'b1, 8'd0, 8'd0);
    while (sent < n) begin
      if ($urandom_range(99) < 3) begin
        burst = $urandom_range(200, 20);
        if (burst > n - sent) burst = n - sent;
        repeat (burst) send_request(tick_req());
        sent += burst;
      end else if ($urandom_range(99) < 30) begin
        send_request(tick_req());
        sent++;
      end else begin
        r = random_sample(r);
        send_request(r);
        sent++;
      end
    end
  endtask

  task automatic test_threshold_sweep(int phase);
    for (int k = 0; k < 3; k++) begin
      drain();
      apply_profile((phase * 3 + k) % 5);
      test_random_traffic(40);
    end
  endtask

  always @(negedge clk) begin
    status_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin : result_check
    fahc_result_t want;
    if (!rst && status_ch.valid && status_ch.ready) begin
      if (pending_outputs.size() == 0) begin
        report_mismatch("result with nothing pending", 1, 0);
      end else begin
        want = pending_outputs.pop_front();
        check_field("smoke_class", status_ch.smoke_class, want.smoke_class);
        check_field("pump_drive", status_ch.pump_drive, want.pump_drive);
        check_field("fan_drive", status_ch.fan_drive, want.fan_drive);
        check_field("buzzer_drive", status_ch.buzzer_drive, want.buzzer_drive);
        check_field("alarm_level", status_ch.alarm_level, want.alarm_level);
        check_field("humidity_shown", status_ch.humidity_shown, want.humidity_shown);
        check_field("temperature_shown", status_ch.temperature_shown,
                    want.temperature_shown);
        check_field("temp_warning", status_ch.temp_warning, want.temp_warning);
        check_field("humidity_warning", status_ch.humidity_warning, want.humidity_warning);
        check_field("reading_valid", status_ch.reading_valid, want.reading_valid);
      end
    end
  end

  always @(posedge clk) begin
    if ((sensor_ch.valid && sensor_ch.ready) || (status_ch.valid && status_ch.ready))
      stall_cycles = 0;
    else
      stall_cycles++;
    if (stall_cycles == STALL_LIMIT) begin
      $display("timeout: no request or result moved for %0d cycles", STALL_LIMIT);
      $display("fire_alarm_hysteresis_controller: mismatch");
      $finish;
    end
  end

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    sensor_ch.valid = 1'b0;
    sensor_ch.mode = ITEM_SAMPLE;
    sensor_ch.smoke_raw = '0;
    sensor_ch.flame = 1'b0;
    sensor_ch.dht_ok = 1'b0;
    sensor_ch.temp_c = '0;
    sensor_ch.hum_pct = '0;
    status_ch.ready = 1'b0;
    mismatches = 0;
    stall_cycles = 0;
    send_idle_pct = 37;
    recv_idle_pct = 84;

    thresholds = '{warn_level: 12'd1600, danger_level: 12'd2000, smoke_margin: 10'd50,
                   temp_warn_c: 8'd40, heat_limit: 8'd60, hum_warn_pct: 8'd80,
                   pump_on_c: 8'd26, fan_on_c: 8'd27};
    smoke_lvl = SMOKE_NORMAL;
    alarm_mode = ALARM_OFF;
    t_warn = 1'b0;
    h_warn = 1'b0;
    pump_on = 1'b0;
    fan_on = 1'b0;
    hum_avg = '0;
    hum_seeded = 1'b0;
    temp_hold = '0;
    hum_hold = '0;
    valid_hold = 1'b0;
    buzz = 1'b0;
    beep_left = '0;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_directed_extremes();
    test_beep_pattern();
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin send_idle_pct = 37; recv_idle_pct = 84; end
        1: begin send_idle_pct = 84; recv_idle_pct = 37; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      test_threshold_sweep(phase);
    end

    drain();
    repeat (20) @(posedge clk);
    if (mismatches == 0)
      $display("fire_alarm_hysteresis_controller: match");
    else
      $display("fire_alarm_hysteresis_controller: mismatch");
    $finish;
  end

endmodule
